[sv/pwra_pkg.sv]
// Shared types and constants for the power window request arbiter.
`default_nettype none

package pwra_pkg;

  localparam int unsigned NUM_SW     = 10;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned CFG_ADDR_W = 1;

  // switch positions in the sampled vector
  localparam int unsigned SW_PASS_UP = 0;
  localparam int unsigned SW_PASS_DN = 1;
  localparam int unsigned SW_DRV_UP  = 2;
  localparam int unsigned SW_DRV_DN  = 3;
  localparam int unsigned SW_LOCK    = 4;
  localparam int unsigned SW_ALL_UP  = 5;
  localparam int unsigned SW_ALL_DN  = 6;
  localparam int unsigned SW_JAM     = 7;
  localparam int unsigned SW_TOP     = 8;
  localparam int unsigned SW_BOT     = 9;

  // move directions
  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UNDEF = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_JAM_STOP_TIME    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_JAM_REVERSE_TIME = 1'd1;

  localparam logic [DUR_W-1:0] JAM_STOP_TIME_RST    = 16'd20;
  localparam logic [DUR_W-1:0] JAM_REVERSE_TIME_RST = 16'd500;

  typedef struct packed {
    logic             motor_on;
    logic [1:0]       move_direction;
    logic [DUR_W-1:0] duration_ms;
    logic             last_of_tick;
  } request_t;

endpackage

`default_nettype wire

[sv/power_window_request_arbiter.sv]
// Power window request arbiter: switch filtering, one-touch latches, priority pick.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_valid / in_stall    | ten raw switch samples, one per tick
//  out_    | out | out_valid / out_stall  | motor_on, move_direction, duration_ms, last_of_tick
//  cfg_    | in  | cfg_wr_en              | cfg_addr, cfg_wdata (jam stop / reverse times)
//
// A tick is taken while in_stall is low and its request appears in the output register the
// next cycle; ticks can follow every cycle while in_stall stays low. A jam tick makes two
// requests: the second waits in a single pending slot behind the output register.
// rst_n (sync, active low) clears switch histories, latches, held direction, both
// timing registers to their defaults and the output/pending valids.
// in_stall is high while the pending slot is full or a stalled request holds the output.
`default_nettype none

module power_window_request_arbiter
  import pwra_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // tick input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_passenger_up_raw,
  input  wire logic                  in_passenger_down_raw,
  input  wire logic                  in_driver_up_raw,
  input  wire logic                  in_driver_down_raw,
  input  wire logic                  in_driver_lock_raw,
  input  wire logic                  in_all_up_raw,
  input  wire logic                  in_all_down_raw,
  input  wire logic                  in_jam_raw,
  input  wire logic                  in_top_limit_raw,
  input  wire logic                  in_bottom_limit_raw,
  // request output
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_motor_on,
  output logic [1:0]                 out_move_direction,
  output logic [DUR_W-1:0]           out_duration_ms,
  output logic                       out_last_of_tick,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [DUR_W-1:0]      cfg_wdata
);

  logic [WINDOW-1:0] hist_r   [NUM_SW];
  logic [WINDOW-1:0] hist_nxt [NUM_SW];
  logic [NUM_SW-1:0] raw;
  logic [NUM_SW-1:0] pressed;

  logic              up_latch_r, up_latch_nxt;
  logic              dn_latch_r, dn_latch_nxt;
  logic [1:0]        held_dir_r, held_dir_nxt;
  logic [DUR_W-1:0]  stop_time_r, reverse_time_r;

  request_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  request_t          pend_r, pend_nxt;
  logic              pend_valid_r, pend_valid_nxt;

  request_t          res0, res1;
  logic              accept, out_take;

  assign raw[SW_PASS_UP] = in_passenger_up_raw;
  assign raw[SW_PASS_DN] = in_passenger_down_raw;
  assign raw[SW_DRV_UP]  = in_driver_up_raw;
  assign raw[SW_DRV_DN]  = in_driver_down_raw;
  assign raw[SW_LOCK]    = in_driver_lock_raw;
  assign raw[SW_ALL_UP]  = in_all_up_raw;
  assign raw[SW_ALL_DN]  = in_all_down_raw;
  assign raw[SW_JAM]     = in_jam_raw;
  assign raw[SW_TOP]     = in_top_limit_raw;
  assign raw[SW_BOT]     = in_bottom_limit_raw;

  assign in_stall = pend_valid_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  // shift in the new sample; a switch is pressed once its whole window is ones
  always_comb begin
    for (int i = 0; i < NUM_SW; i++) begin
      hist_nxt[i] = WINDOW'({hist_r[i], raw[i]});
      pressed[i]  = &hist_nxt[i];
    end
  end

  // request selection
  always_comb begin
    logic       on;
    logic [1:0] dir;
    on           = 1'b0;
    dir          = DIR_UNDEF;
    up_latch_nxt = up_latch_r | pressed[SW_ALL_UP];
    dn_latch_nxt = dn_latch_r | pressed[SW_ALL_DN];
    res1         = '{motor_on: 1'b1, move_direction: DIR_DOWN,
                     duration_ms: reverse_time_r, last_of_tick: 1'b1};
    priority if (pressed[SW_JAM]) begin
      up_latch_nxt = 1'b0;
      dn_latch_nxt = 1'b0;
    end else if (pressed[SW_TOP] || pressed[SW_BOT]) begin
      up_latch_nxt = 1'b0;
      dn_latch_nxt = 1'b0;
    end else if (up_latch_nxt) begin
      on = 1'b1; dir = DIR_UP;
    end else if (dn_latch_nxt) begin
      on = 1'b1; dir = DIR_DOWN;
    end else if (pressed[SW_DRV_UP]) begin
      on = 1'b1; dir = DIR_UP;
    end else if (pressed[SW_DRV_DN]) begin
      on = 1'b1; dir = DIR_DOWN;
    end else if (pressed[SW_PASS_UP] && !pressed[SW_LOCK]) begin
      on = 1'b1; dir = DIR_UP;
    end else if (pressed[SW_PASS_DN] && !pressed[SW_LOCK]) begin
      on = 1'b1; dir = DIR_DOWN;
    end else begin
      on = 1'b0; dir = DIR_UNDEF;
    end

    if (pressed[SW_JAM]) begin
      // timed stop that keeps the previous direction, then the reverse move
      res0         = '{motor_on: 1'b0, move_direction: held_dir_r,
                       duration_ms: stop_time_r, last_of_tick: 1'b0};
      held_dir_nxt = DIR_DOWN;
    end else begin
      res0         = '{motor_on: on, move_direction: dir,
                       duration_ms: '0, last_of_tick: 1'b1};
      held_dir_nxt = dir;
    end
  end

  // output register plus one pending slot for the second jam request
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (accept) begin
      out_nxt        = res0;
      out_valid_nxt  = 1'b1;
      pend_nxt       = res1;
      pend_valid_nxt = pressed[SW_JAM];
    end else if (out_take) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SW; i++) begin
        hist_r[i] <= '0;
      end
      up_latch_r     <= 1'b0;
      dn_latch_r     <= 1'b0;
      held_dir_r     <= DIR_NONE;
      out_valid_r    <= 1'b0;
      pend_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < NUM_SW; i++) begin
          hist_r[i] <= hist_nxt[i];
        end
        up_latch_r <= up_latch_nxt;
        dn_latch_r <= dn_latch_nxt;
        held_dir_r <= held_dir_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_time_r    <= JAM_STOP_TIME_RST;
      reverse_time_r <= JAM_REVERSE_TIME_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_JAM_STOP_TIME:    stop_time_r    <= cfg_wdata;
        CFG_JAM_REVERSE_TIME: reverse_time_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_motor_on       = out_r.motor_on;
  assign out_move_direction = out_r.move_direction;
  assign out_duration_ms    = out_r.duration_ms;
  assign out_last_of_tick   = out_r.last_of_tick;

endmodule

`default_nettype wire

[sv/pwra_checker.sv]
// Port-level checks for the power window request arbiter, bound to the top level.
`default_nettype none

module pwra_checker
  import pwra_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  out_motor_on,
  input wire logic [1:0]            out_move_direction,
  input wire logic [DUR_W-1:0]      out_duration_ms,
  input wire logic                  out_last_of_tick
);

  // a held request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor_on)
      && $stable(out_move_direction) && $stable(out_duration_ms)
      && $stable(out_last_of_tick))
    else $error("output transaction changed while stalled");

  // the first request of a jam tick is always a stop
  a_jam_first_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_tick |-> !out_motor_on)
    else $error("first jam request is not a stop");

  // the reverse move follows directly
  a_jam_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_tick && !out_stall |=>
      out_valid && out_last_of_tick && out_motor_on && out_move_direction == DIR_DOWN)
    else $error("jam reverse request missing");

  // no new tick while the jam pair is still being delivered
  a_jam_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_tick |-> in_stall)
    else $error("input accepted during jam request pair");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind power_window_request_arbiter pwra_checker u_pwra_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_motor_on       (out_motor_on),
  .out_move_direction (out_move_direction),
  .out_duration_ms    (out_duration_ms),
  .out_last_of_tick   (out_last_of_tick)
);

`default_nettype wire
